### hdl/gspg_pkg.sv
// Shared types, register map and exponent table for the Gaussian spot pixel generator.
`timescale 1ns / 1ps

package gspg_pkg;

   localparam int MAX_DIM        = 4096;
   localparam int EXP_TABLE_SIZE = 256;
   localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
   localparam int EXP_W          = 17;
   localparam int ROOT_FRAC      = 60;

   localparam int ROWS_W  = 13;
   localparam int COORD_W = 12;
   localparam int HW_W    = 8;
   localparam int AMP_W   = 16;
   localparam int RATE_W  = 24;
   localparam int D2_W    = 2 * HW_W + 1;
   localparam int Z_W     = D2_W + RATE_W;
   localparam int PROD_W  = AMP_W + EXP_W;
   localparam int VAL_W   = PROD_W - 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [ROWS_W-1:0] MAX_DIM_VAL = ROWS_W'(MAX_DIM);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_ROWS   = 3'd0,
      CSR_IMAGE_COLS   = 3'd1,
      CSR_CENTER_ROW   = 3'd2,
      CSR_CENTER_COL   = 3'd3,
      CSR_HALF_WIDTH   = 3'd4,
      CSR_AMPLITUDE_Q8 = 3'd5,
      CSR_RATE_Q16     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [ROWS_W-1:0]  image_rows;
      logic [ROWS_W-1:0]  image_cols;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
      logic [HW_W-1:0]    half_width;
      logic [AMP_W-1:0]   amplitude_q8;
      logic [RATE_W-1:0]  rate_q16;
   } cfg_type;

   // Integer square root of a 128-bit value, one result bit per step.
   function automatic logic [63:0] isqrt128(input logic [127:0] v);
      logic [63:0]  res;
      logic [63:0]  t;
      logic [127:0] sq;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         t  = res | (64'd1 << b);
         sq = 128'(t) * 128'(t);
         if (sq <= v) begin
            res = t;
         end
      end
      return res;
   endfunction

   // Entry k = round(65536 * 2^(-k/EXP_TABLE_SIZE)), evaluated at elaboration.
   // The root 2^(-1/EXP_TABLE_SIZE) comes from repeated square roots of one half.
   function automatic logic [EXP_TABLE_SIZE*EXP_W-1:0] build_exp_table();
      logic [EXP_TABLE_SIZE*EXP_W-1:0] tbl;
      logic [127:0] root;
      logic [127:0] p;
      logic [127:0] e;
      tbl  = '0;
      root = 128'd1 << (ROOT_FRAC - 1);
      for (int i = 0; i < EXP_IDX_W; i++) begin
         root = 128'(isqrt128(root << ROOT_FRAC));
      end
      p = 128'd1 << ROOT_FRAC;
      for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
         e = (p + (128'd1 << (ROOT_FRAC - 17))) >> (ROOT_FRAC - 16);
         tbl[k*EXP_W +: EXP_W] = e[EXP_W-1:0];
         p = (p * root) >> ROOT_FRAC;
      end
      return tbl;
   endfunction

   localparam logic [EXP_TABLE_SIZE*EXP_W-1:0] EXP_TABLE = build_exp_table();

   function automatic logic [EXP_W-1:0] exp_lookup(input logic [EXP_IDX_W-1:0] idx);
      return EXP_TABLE[int'(idx)*EXP_W +: EXP_W];
   endfunction

endpackage

### hdl/gspg_csr.sv
// Configuration register bank for the Gaussian spot pixel generator.
`timescale 1ns / 1ps

module gspg_csr
   import gspg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_ROWS:   cfg_in.image_rows   = csr_wdata[ROWS_W-1:0];
            CSR_IMAGE_COLS:   cfg_in.image_cols   = csr_wdata[ROWS_W-1:0];
            CSR_CENTER_ROW:   cfg_in.center_row   = csr_wdata[COORD_W-1:0];
            CSR_CENTER_COL:   cfg_in.center_col   = csr_wdata[COORD_W-1:0];
            CSR_HALF_WIDTH:   cfg_in.half_width   = csr_wdata[HW_W-1:0];
            CSR_AMPLITUDE_Q8: cfg_in.amplitude_q8 = csr_wdata[AMP_W-1:0];
            CSR_RATE_Q16:     cfg_in.rate_q16     = csr_wdata[RATE_W-1:0];
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_rows   <= ROWS_W'(1024);
         cfg_ff.image_cols   <= ROWS_W'(1024);
         cfg_ff.center_row   <= COORD_W'(512);
         cfg_ff.center_col   <= COORD_W'(512);
         cfg_ff.half_width   <= HW_W'(5);
         cfg_ff.amplitude_q8 <= AMP_W'(25600);
         cfg_ff.rate_q16     <= RATE_W'(47274);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/gspg_pipe.sv
// Six-stage pixel datapath: bounds, distance, exponent, table, scale, output.
`timescale 1ns / 1ps

module gspg_pipe
   import gspg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_pixel_row,
   input  logic [COORD_W-1:0] req_pixel_col,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_pixel_value,
   output logic               rsp_in_window,
   output logic               rsp_out_of_image
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic en1, en2, en3, en4, en5, en6;

   // Each stage advances when empty or when the next one advances.
   assign en6 = !s6_valid_ff || rsp_ready;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1;

   // Stage 1: image bounds, distance to centre, window test.
   logic [ROWS_W-1:0]  rows_cap, cols_cap;
   logic               ooi_in;
   logic [COORD_W-1:0] dr_in, dc_in;
   logic               win_in;
   logic               s1_ooi_ff, s1_win_ff;
   logic [HW_W-1:0]    s1_dr_ff, s1_dc_ff;

   always_comb begin
      rows_cap = (cfg.image_rows > MAX_DIM_VAL) ? MAX_DIM_VAL : cfg.image_rows;
      cols_cap = (cfg.image_cols > MAX_DIM_VAL) ? MAX_DIM_VAL : cfg.image_cols;
      ooi_in   = ({1'b0, req_pixel_row} >= rows_cap) || ({1'b0, req_pixel_col} >= cols_cap);
      dr_in    = (req_pixel_row >= cfg.center_row) ? req_pixel_row - cfg.center_row
                                                   : cfg.center_row - req_pixel_row;
      dc_in    = (req_pixel_col >= cfg.center_col) ? req_pixel_col - cfg.center_col
                                                   : cfg.center_col - req_pixel_col;
      win_in   = !ooi_in && (dr_in <= COORD_W'(cfg.half_width))
                         && (dc_in <= COORD_W'(cfg.half_width));
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ooi_ff <= ooi_in;
         s1_win_ff <= win_in;
         s1_dr_ff  <= dr_in[HW_W-1:0];
         s1_dc_ff  <= dc_in[HW_W-1:0];
      end
   end

   // Stage 2: squared distance (bounded by the window).
   logic [D2_W-1:0] d2_in;
   logic [D2_W-1:0] s2_d2_ff;
   logic            s2_ooi_ff, s2_win_ff;

   assign d2_in = D2_W'(s1_dr_ff * s1_dr_ff) + D2_W'(s1_dc_ff * s1_dc_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_d2_ff  <= d2_in;
         s2_ooi_ff <= s1_ooi_ff;
         s2_win_ff <= s1_win_ff;
      end
   end

   // Stage 3: exponent z = d^2 * rate, Q.16.
   logic [Z_W-1:0] z_in;
   logic [Z_W-1:0] s3_z_ff;
   logic           s3_ooi_ff, s3_win_ff;

   assign z_in = Z_W'(s2_d2_ff) * Z_W'(cfg.rate_q16);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_z_ff   <= z_in;
         s3_ooi_ff <= s2_ooi_ff;
         s3_win_ff <= s2_win_ff;
      end
   end

   // Stage 4: table lookup on the top fraction bits, shift by the integer part.
   logic             big_exp;
   logic [EXP_W-1:0] entry;
   logic [EXP_W-1:0] g_in;
   logic [EXP_W-1:0] s4_g_ff;
   logic             s4_ooi_ff, s4_win_ff;

   always_comb begin
      big_exp = |s3_z_ff[Z_W-1:20];
      entry   = exp_lookup(s3_z_ff[15 -: EXP_IDX_W]);
      g_in    = (big_exp || !s3_win_ff) ? '0 : (entry >> s3_z_ff[19:16]);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_g_ff   <= g_in;
         s4_ooi_ff <= s3_ooi_ff;
         s4_win_ff <= s3_win_ff;
      end
   end

   // Stage 5: scale by amplitude.
   logic [PROD_W-1:0] prod_in;
   logic [VAL_W-1:0]  s5_v_ff;
   logic              s5_ooi_ff, s5_win_ff;

   assign prod_in = PROD_W'(cfg.amplitude_q8) * PROD_W'(s4_g_ff);

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_v_ff   <= prod_in[PROD_W-1:16];
         s5_ooi_ff <= s4_ooi_ff;
         s5_win_ff <= s4_win_ff;
      end
   end

   // Stage 6: saturate into the output register; hold while the beat waits.
   logic [15:0] val_in;
   logic [15:0] s6_val_ff;
   logic        s6_ooi_ff, s6_win_ff;

   assign val_in = (s5_v_ff > VAL_W'(16'hFFFF)) ? 16'hFFFF : s5_v_ff[15:0];

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_val_ff <= val_in;
         s6_ooi_ff <= s5_ooi_ff;
         s6_win_ff <= s5_win_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
         if (en6) s6_valid_ff <= s5_valid_ff;
      end
   end

   assign rsp_valid        = s6_valid_ff;
   assign rsp_pixel_value  = s6_val_ff;
   assign rsp_in_window    = s6_win_ff;
   assign rsp_out_of_image = s6_ooi_ff;

endmodule

### hdl/gaussian_spot_pixel_generator.sv
// Top level of the Gaussian spot pixel generator.
// Path: a request beat passes the stage 1 to 6 registers to its response beat.
// Throughput: one pixel per cycle, set by the six-stage datapath with stall per stage.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
// No clearing pass: the exponent table is constant logic.
`timescale 1ns / 1ps

module gaussian_spot_pixel_generator
   import gspg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_W-1:0]    req_pixel_row,
   input  logic [COORD_W-1:0]    req_pixel_col,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_pixel_value,
   output logic                  rsp_in_window,
   output logic                  rsp_out_of_image
);

   cfg_type cfg;

   gspg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gspg_pipe u_pipe (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_in_window    (rsp_in_window),
      .rsp_out_of_image (rsp_out_of_image)
   );

endmodule
